// ----- hw/rtl/q2e_pkg.sv -----
// Shared types and constants of the quaternion to Euler angle converter.
// No dependencies; used by q2e_vec_angle and quaternion_to_euler.
package q2e_pkg;

    // Internal component format is signed Q2.20.
    localparam int IW        = 22;
    localparam int PROD_W    = 2 * IW;
    localparam int SUM_W     = PROD_W + 2;
    localparam int S30_W     = 32;
    localparam int SQ_W      = 62;
    localparam int C30_W     = 31;
    localparam int VEC_W     = 48;
    localparam int CORD_W    = 50;
    localparam int ANG_W     = 23;
    localparam int DEG_W     = 54;

    localparam int NORM_STAGES  = 6;
    localparam int NORM_BIT     = 45;
    localparam int CORDIC_STEPS = 20;
    localparam int SQRT_STEPS   = 31;
    localparam int VEC_LAT      = NORM_STAGES + 1 + CORDIC_STEPS;
    localparam int SIDE_DLY     = SQRT_STEPS + 3;
    localparam int LATENCY      = 6 + SQRT_STEPS + VEC_LAT + 2;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = 23'sd1647099;
    localparam logic signed [SUM_W-1:0] PITCH_LIMIT = 46'sd549755264132;
    localparam logic signed [SUM_W-1:0] ONE_Q40     = 46'sd1 <<< 40;
    localparam logic signed [30:0]      DEG_PER_RAD = 31'sd480631834;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        23'sd823550, 23'sd486170, 23'sd256879, 23'sd130396, 23'sd65451,
        23'sd32757,  23'sd16383,  23'sd8192,   23'sd4096,   23'sd2048,
        23'sd1024,   23'sd512,    23'sd256,    23'sd128,    23'sd64,
        23'sd32,     23'sd16,     23'sd8,      23'sd4,      23'sd2
    };

    typedef struct packed {
        logic clamp;
        logic neg;
    } t_pflag;

    typedef struct packed {
        logic signed [SUM_W-1:0] roll_y;
        logic signed [SUM_W-1:0] roll_x;
        logic signed [SUM_W-1:0] yaw_y;
        logic signed [SUM_W-1:0] yaw_x;
        logic signed [S30_W-1:0] s30;
        t_pflag                  flags;
    } t_side;

endpackage

// ----- hw/rtl/q2e_vec_angle.sv -----
// Pipelined vector angle (atan2) unit: normalizing shifter, quadrant
// pre-rotation and a 20-step vectoring CORDIC. Depends on q2e_pkg.
module q2e_vec_angle (
    input  logic                                i_clk,
    input  logic signed [q2e_pkg::VEC_W-1:0]    i_y,
    input  logic signed [q2e_pkg::VEC_W-1:0]    i_x,
    output logic signed [q2e_pkg::ANG_W-1:0]    o_angle
);
    import q2e_pkg::*;

    function automatic logic [VEC_W-1:0] mag(input logic signed [VEC_W-1:0] v);
        return v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
    endfunction

    logic signed [VEC_W-1:0] w_nx [NORM_STAGES+1];
    logic signed [VEC_W-1:0] w_ny [NORM_STAGES+1];
    logic                    w_nz [NORM_STAGES+1];
    logic signed [VEC_W-1:0] r_nx [NORM_STAGES];
    logic signed [VEC_W-1:0] r_ny [NORM_STAGES];
    logic                    r_nz [NORM_STAGES];

    assign w_nx[0] = i_x;
    assign w_ny[0] = i_y;
    assign w_nz[0] = (i_x == '0) && (i_y == '0);

    // Binary search for the doubling count that lifts the larger
    // magnitude into [2^45, 2^46).
    for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
        localparam int SH = 32 >> k;
        localparam logic [VEC_W-1:0] LIM = VEC_W'(1) << (NORM_BIT + 1 - SH);
        always_ff @(posedge i_clk) begin
            if (mag(w_nx[k]) < LIM && mag(w_ny[k]) < LIM) begin
                r_nx[k] <= w_nx[k] <<< SH;
                r_ny[k] <= w_ny[k] <<< SH;
            end else begin
                r_nx[k] <= w_nx[k];
                r_ny[k] <= w_ny[k];
            end
            r_nz[k] <= w_nz[k];
        end
        assign w_nx[k+1] = r_nx[k];
        assign w_ny[k+1] = r_ny[k];
        assign w_nz[k+1] = r_nz[k];
    end

    logic signed [CORD_W-1:0] r_px;
    logic signed [CORD_W-1:0] r_py;
    logic signed [ANG_W-1:0]  r_pa;
    logic                     r_pz;

    always_ff @(posedge i_clk) begin
        if (w_nx[NORM_STAGES] < 0) begin
            if (w_ny[NORM_STAGES] >= 0) begin
                r_px <= CORD_W'(w_ny[NORM_STAGES]);
                r_py <= -CORD_W'(w_nx[NORM_STAGES]);
                r_pa <= HALF_PI_Q20;
            end else begin
                r_px <= -CORD_W'(w_ny[NORM_STAGES]);
                r_py <= CORD_W'(w_nx[NORM_STAGES]);
                r_pa <= -HALF_PI_Q20;
            end
        end else begin
            r_px <= CORD_W'(w_nx[NORM_STAGES]);
            r_py <= CORD_W'(w_ny[NORM_STAGES]);
            r_pa <= '0;
        end
        r_pz <= w_nz[NORM_STAGES];
    end

    logic signed [CORD_W-1:0] w_cx [CORDIC_STEPS+1];
    logic signed [CORD_W-1:0] w_cy [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0]  w_ca [CORDIC_STEPS+1];
    logic                     w_cz [CORDIC_STEPS+1];
    logic signed [CORD_W-1:0] r_cx [CORDIC_STEPS];
    logic signed [CORD_W-1:0] r_cy [CORDIC_STEPS];
    logic signed [ANG_W-1:0]  r_ca [CORDIC_STEPS];
    logic                     r_cz [CORDIC_STEPS];

    assign w_cx[0] = r_px;
    assign w_cy[0] = r_py;
    assign w_ca[0] = r_pa;
    assign w_cz[0] = r_pz;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (w_cy[i] >= 0) begin
                r_cx[i] <= w_cx[i] + (w_cy[i] >>> i);
                r_cy[i] <= w_cy[i] - (w_cx[i] >>> i);
                r_ca[i] <= w_ca[i] + ATAN_TAB[i];
            end else begin
                r_cx[i] <= w_cx[i] - (w_cy[i] >>> i);
                r_cy[i] <= w_cy[i] + (w_cx[i] >>> i);
                r_ca[i] <= w_ca[i] - ATAN_TAB[i];
            end
            r_cz[i] <= w_cz[i];
        end
        assign w_cx[i+1] = r_cx[i];
        assign w_cy[i+1] = r_cy[i];
        assign w_ca[i+1] = r_ca[i];
        assign w_cz[i+1] = r_cz[i];
    end

    // A zero vector has no direction; it reports angle zero.
    assign o_angle = w_cz[CORDIC_STEPS] ? '0 : w_ca[CORDIC_STEPS];

endmodule

// ----- hw/rtl/quaternion_to_euler.sv -----
// Top level of the quaternion to Euler angle converter.
// Depends on q2e_pkg and q2e_vec_angle.

// One quaternion is taken each cycle that start is high; busy never rises,
// and the angles appear with o_strobe for one cycle. The path runs through the
// 31-stage square-root pipeline of the pitch path, followed by the normalizer,
// pre-rotation and 20 CORDIC stages. The result beat cannot be held off, so a
// receiver must take every strobe. The unit bit is sampled at the output, so
// write it only while no beat is in flight.
module quaternion_to_euler #(
    parameter int QUAT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [QUAT_WIDTH-1:0] i_quat_w,
    input  logic signed [QUAT_WIDTH-1:0] i_quat_x,
    input  logic signed [QUAT_WIDTH-1:0] i_quat_y,
    input  logic signed [QUAT_WIDTH-1:0] i_quat_z,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    output logic                         o_strobe,
    output logic signed [15:0]           o_pitch_angle,
    output logic signed [15:0]           o_yaw_angle,
    output logic signed [15:0]           o_roll_angle,
    output logic                         o_pitch_clamped
);
    import q2e_pkg::*;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        if (v > 32'sd32767) return 16'sh7fff;
        if (v < -32'sd32768) return 16'sh8000;
        return 16'(v);
    endfunction

    assign busy = 1'b0;

    logic r_angle_unit;
    logic [LATENCY-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_unit <= 1'b0;
            r_vld        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_angle_unit <= i_cfg_wdata;
            end
            r_vld <= {r_vld[LATENCY-2:0], start && !busy};
        end
    end

    // Stage 1: bring components to Q2.20.
    logic signed [IW-1:0] w_qin [4];
    logic signed [IW-1:0] r_q   [4];

    if (QUAT_WIDTH > IW) begin : g_narrow
        assign w_qin[0] = IW'(i_quat_w >>> (QUAT_WIDTH - IW));
        assign w_qin[1] = IW'(i_quat_x >>> (QUAT_WIDTH - IW));
        assign w_qin[2] = IW'(i_quat_y >>> (QUAT_WIDTH - IW));
        assign w_qin[3] = IW'(i_quat_z >>> (QUAT_WIDTH - IW));
    end else begin : g_widen
        assign w_qin[0] = IW'(i_quat_w) <<< (IW - QUAT_WIDTH);
        assign w_qin[1] = IW'(i_quat_x) <<< (IW - QUAT_WIDTH);
        assign w_qin[2] = IW'(i_quat_y) <<< (IW - QUAT_WIDTH);
        assign w_qin[3] = IW'(i_quat_z) <<< (IW - QUAT_WIDTH);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_q[k] <= w_qin[k];
        end
    end

    // Stage 2: products in Q40.
    logic signed [PROD_W-1:0] r_wz, r_xy, r_zz, r_xx, r_wy, r_xz, r_yy, r_wx, r_yz;

    always_ff @(posedge i_clk) begin
        r_wz <= r_q[0] * r_q[3];
        r_xy <= r_q[1] * r_q[2];
        r_zz <= r_q[3] * r_q[3];
        r_xx <= r_q[1] * r_q[1];
        r_wy <= r_q[0] * r_q[2];
        r_xz <= r_q[1] * r_q[3];
        r_yy <= r_q[2] * r_q[2];
        r_wx <= r_q[0] * r_q[1];
        r_yz <= r_q[2] * r_q[3];
    end

    // Stage 3: vector components and the pitch sine term.
    logic signed [SUM_W-1:0] r_roll_y, r_roll_x, r_yaw_y, r_yaw_x, r_t;

    always_ff @(posedge i_clk) begin
        r_roll_y <= (SUM_W'(r_wz) + SUM_W'(r_xy)) <<< 1;
        r_roll_x <= ONE_Q40 - ((SUM_W'(r_zz) + SUM_W'(r_xx)) <<< 1);
        r_yaw_y  <= (SUM_W'(r_wy) + SUM_W'(r_xz)) <<< 1;
        r_yaw_x  <= ONE_Q40 - ((SUM_W'(r_xx) + SUM_W'(r_yy)) <<< 1);
        r_t      <= SUM_W'(r_wx) - SUM_W'(r_yz);
    end

    // Stage 4 onward: side data rides along the square-root pipeline.
    t_side r_side [SIDE_DLY];

    always_ff @(posedge i_clk) begin
        r_side[0].roll_y      <= r_roll_y;
        r_side[0].roll_x      <= r_roll_x;
        r_side[0].yaw_y       <= r_yaw_y;
        r_side[0].yaw_x       <= r_yaw_x;
        r_side[0].s30         <= S30_W'(r_t >>> 9);
        r_side[0].flags.clamp <= (r_t < -PITCH_LIMIT) || (r_t > PITCH_LIMIT);
        r_side[0].flags.neg   <= r_t < 0;
        for (int k = 1; k < SIDE_DLY; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // Stages 5 and 6: radicand 2^60 - s*s.
    logic signed [2*S30_W-1:0] w_sq_full;
    logic [SQ_W-1:0] r_sq;
    logic [SQ_W-1:0] r_rad;

    assign w_sq_full = r_side[0].s30 * r_side[0].s30;

    always_ff @(posedge i_clk) begin
        r_sq  <= w_sq_full[SQ_W-1:0];
        r_rad <= (SQ_W'(1) << 60) - r_sq;
    end

    // Square root, one result bit per stage.
    logic [SQ_W-1:0] w_sn [SQRT_STEPS+1];
    logic [SQ_W-1:0] w_sr [SQRT_STEPS+1];
    logic [SQ_W-1:0] r_sn [SQRT_STEPS];
    logic [SQ_W-1:0] r_sr [SQRT_STEPS];

    assign w_sn[0] = r_rad;
    assign w_sr[0] = '0;

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (60 - 2 * j);
        always_ff @(posedge i_clk) begin
            if (w_sn[j] >= w_sr[j] + BIT) begin
                r_sn[j] <= w_sn[j] - (w_sr[j] + BIT);
                r_sr[j] <= (w_sr[j] >> 1) + BIT;
            end else begin
                r_sn[j] <= w_sn[j];
                r_sr[j] <= w_sr[j] >> 1;
            end
        end
        assign w_sn[j+1] = r_sn[j];
        assign w_sr[j+1] = r_sr[j];
    end

    // Three angle units in parallel.
    logic signed [VEC_W-1:0] w_py, w_px;
    logic signed [ANG_W-1:0] w_ang [3];

    assign w_py = VEC_W'(r_side[SIDE_DLY-1].s30);
    assign w_px = VEC_W'({1'b0, w_sr[SQRT_STEPS][C30_W-1:0]});

    q2e_vec_angle u_pitch (
        .i_clk   (i_clk),
        .i_y     (w_py),
        .i_x     (w_px),
        .o_angle (w_ang[0])
    );

    q2e_vec_angle u_yaw (
        .i_clk   (i_clk),
        .i_y     (VEC_W'(r_side[SIDE_DLY-1].yaw_y)),
        .i_x     (VEC_W'(r_side[SIDE_DLY-1].yaw_x)),
        .o_angle (w_ang[1])
    );

    q2e_vec_angle u_roll (
        .i_clk   (i_clk),
        .i_y     (VEC_W'(r_side[SIDE_DLY-1].roll_y)),
        .i_x     (VEC_W'(r_side[SIDE_DLY-1].roll_x)),
        .o_angle (w_ang[2])
    );

    t_pflag r_flag [VEC_LAT];

    always_ff @(posedge i_clk) begin
        r_flag[0] <= r_side[SIDE_DLY-1].flags;
        for (int k = 1; k < VEC_LAT; k++) begin
            r_flag[k] <= r_flag[k-1];
        end
    end

    // Pitch beyond the limit is forced to a right angle.
    logic signed [ANG_W-1:0] w_sel [3];

    always_comb begin
        w_sel[0] = w_ang[0];
        w_sel[1] = w_ang[1];
        w_sel[2] = w_ang[2];
        if (r_flag[VEC_LAT-1].clamp) begin
            w_sel[0] = r_flag[VEC_LAT-1].neg ? -HALF_PI_Q20 : HALF_PI_Q20;
        end
    end

    logic signed [ANG_W-1:0] r_arad [3];
    logic signed [DEG_W-1:0] r_adeg [3];
    logic                    r_clamp;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_arad[k] <= w_sel[k];
            r_adeg[k] <= w_sel[k] * DEG_PER_RAD;
        end
        r_clamp <= r_flag[VEC_LAT-1].clamp;
    end

    logic signed [15:0] w_out [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_angle_unit) begin
                w_out[k] = sat16(32'((r_adeg[k] + (DEG_W'(1) <<< 35)) >>> 36));
            end else begin
                w_out[k] = sat16(32'((32'(r_arad[k]) + 32'sd64) >>> 7));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_pitch_angle   <= w_out[0];
        o_yaw_angle     <= w_out[1];
        o_roll_angle    <= w_out[2];
        o_pitch_clamped <= r_clamp;
    end

    assign o_strobe = r_vld[LATENCY-1];

endmodule
